FILE: design/call_arc_counter_unit_defines.svh
// Assertion macros shared by the checker.
`ifndef CALL_ARC_COUNTER_UNIT_DEFINES_SVH
`define CALL_ARC_COUNTER_UNIT_DEFINES_SVH
`define CAC_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("check failed");
`define CAC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("check failed");
`endif

FILE: design/cac_pkg.sv
package cac_pkg;
    localparam int BUCKET_COUNT = 4096;
    localparam int ARC_SLOTS = 1024;
    localparam int BUCKET_BYTES = 8;
    localparam int PC_WIDTH = 32;
    localparam int OUTCOME_W = 3;
    localparam int SLOT_OUT_W = 10;
    localparam int COUNT_W = 32;

    typedef enum logic [2:0] {
        OUT_HEAD  = 3'd0,
        OUT_MOVED = 3'd1,
        OUT_NEW   = 3'd2,
        OUT_OFF   = 3'd3,
        OUT_RANGE = 3'd4,
        OUT_FULL  = 3'd5
    } outcome_t;

    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_BASE   = 2'd1;
    localparam logic [1:0] REG_SIZE   = 2'd2;
    localparam logic [1:0] REG_LIMIT  = 2'd3;
endpackage

FILE: design/cac_event_if.sv
interface cac_event_if #(parameter int PC_W = cac_pkg::PC_WIDTH);
    logic            valid;
    logic            ready;
    logic [PC_W-1:0] caller_pc;
    logic [PC_W-1:0] callee_pc;
    modport source (output valid, caller_pc, callee_pc, input ready);
    modport sink (input valid, caller_pc, callee_pc, output ready);
endinterface

FILE: design/cac_result_if.sv
interface cac_result_if;
    logic                          valid;
    logic                          ready;
    logic [cac_pkg::OUTCOME_W-1:0] outcome;
    logic [cac_pkg::SLOT_OUT_W-1:0] arc_slot;
    logic [cac_pkg::COUNT_W-1:0]   call_count;
    modport source (output valid, outcome, arc_slot, call_count, input ready);
    modport sink (input valid, outcome, arc_slot, call_count, output ready);
endinterface

FILE: design/call_arc_counter_unit.sv
// Channel   Role    Payload
// evt       sink    caller_pc, callee_pc
// res       source  outcome, arc_slot, call_count
// apb       slave   enable, text_base, text_size, arc_limit
// After reset a clearing pass writes every bucket head, one a cycle; no event is taken
// meanwhile. A dropped event's result is valid in the cycle after it is taken.
// A head hit steps through S_HEAD, S_HWAIT, S_NWAIT and S_CHK, and each further chain entry
// through S_NEXT, S_OUT, S_NWAIT and S_CHK, set by the single read port of each arc memory.
// A moved hit adds link writes in S_MOVE1 and S_MOVE2; a miss adds S_NEXT and S_ALLOC,
// or runs S_HEAD, S_HWAIT and S_ALLOC when the bucket is empty.
// No event is taken while a finished word waits in the output register.
module call_arc_counter_unit #(
    parameter int BUCKET_COUNT = cac_pkg::BUCKET_COUNT,
    parameter int ARC_SLOTS = cac_pkg::ARC_SLOTS,
    parameter int BUCKET_BYTES = cac_pkg::BUCKET_BYTES,
    parameter int PC_WIDTH = cac_pkg::PC_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    cac_event_if.sink   evt,
    cac_result_if.source res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int BW = $clog2(BUCKET_COUNT);
    localparam int SW = $clog2(ARC_SLOTS);
    localparam int LW = SW + 1;
    localparam int OW = PC_WIDTH;
    localparam int SHIFT = $clog2(BUCKET_BYTES);
    localparam logic [1:0] REG_ENABLE_C = cac_pkg::REG_ENABLE;
    localparam logic [1:0] REG_BASE_C = cac_pkg::REG_BASE;
    localparam logic [1:0] REG_SIZE_C = cac_pkg::REG_SIZE;
    localparam logic [1:0] REG_LIMIT_C = cac_pkg::REG_LIMIT;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HEAD, S_HWAIT, S_CHK, S_NEXT, S_NWAIT,
        S_MOVE1, S_MOVE2, S_ALLOC, S_OUT
    } state_t;

    state_t state_reg;
    logic [BW-1:0] clr_reg;
    logic en_reg;
    logic [31:0] base_reg;
    logic [15:0] size_reg;
    logic [10:0] limit_reg;
    logic [SW-1:0] free_reg;

    logic [SW-1:0] heads_mem [BUCKET_COUNT];
    logic [PC_WIDTH-1:0] callee_mem [ARC_SLOTS];
    logic [31:0] calls_mem [ARC_SLOTS];
    logic [SW-1:0] next_mem [ARC_SLOTS];

    logic [PC_WIDTH-1:0] callee_reg;
    logic [BW-1:0] bucket_reg;
    logic [SW-1:0] head_reg, prev_reg, cur_reg;
    logic [SW-1:0] head_rd, next_rd;
    logic [PC_WIDTH-1:0] callee_rd;
    logic [31:0] calls_rd;
    logic [SW:0] steps_reg;
    logic at_head_reg;
    logic [2:0] o_outcome_reg;
    logic [SW-1:0] o_slot_reg;
    logic [31:0] o_count_reg;
    logic o_valid_reg;

    logic [OW-1:0] base_al, offset;
    logic [OW-1:0] bucket_wide;
    logic in_range;
    logic [LW-1:0] lim_eff, slot_try;
    logic alloc_ok;
    logic [SW-1:0] new_slot;
    logic [31:0] bumped;
    logic [SW-1:0] head_sel;

    assign pready = 1'b1;
    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_ENABLE_C: prdata = {31'd0, en_reg};
            REG_BASE_C:   prdata = base_reg;
            REG_SIZE_C:   prdata = {16'd0, size_reg};
            REG_LIMIT_C:  prdata = {21'd0, limit_reg};
            default:      prdata = '0;
        endcase
    end

    assign base_al = OW'({base_reg[31:2], 2'b00});
    assign offset = evt.caller_pc - base_al;
    assign bucket_wide = offset >> SHIFT;
    assign in_range = (offset < OW'(size_reg)) && (bucket_wide < OW'(BUCKET_COUNT));
    assign lim_eff = (LW'(limit_reg) < LW'(ARC_SLOTS)) ? LW'(limit_reg) : LW'(ARC_SLOTS);
    assign slot_try = LW'(free_reg) + LW'(1);
    assign alloc_ok = slot_try < lim_eff;
    assign new_slot = SW'(slot_try);
    assign bumped = (calls_rd == 32'hFFFF_FFFF) ? calls_rd : calls_rd + 32'd1;
    assign head_sel = at_head_reg ? head_reg : cur_reg;

    assign evt.ready = (state_reg == S_IDLE) && !o_valid_reg;
    assign res.valid = o_valid_reg;
    assign res.outcome = o_outcome_reg;
    assign res.arc_slot = 10'(o_slot_reg);
    assign res.call_count = o_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg <= 1'b0;
            base_reg <= '0;
            size_reg <= 16'd32768;
            limit_reg <= 11'd1024;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_ENABLE_C: en_reg <= pwdata[0];
                REG_BASE_C:   base_reg <= pwdata;
                REG_SIZE_C:   size_reg <= pwdata[15:0];
                REG_LIMIT_C:  limit_reg <= pwdata[10:0];
                default:      en_reg <= en_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            heads_mem[clr_reg] <= '0;
        else if (state_reg == S_MOVE2 || (state_reg == S_ALLOC && alloc_ok))
            heads_mem[bucket_reg] <= (state_reg == S_ALLOC) ? new_slot : cur_reg;
        head_rd <= heads_mem[bucket_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ALLOC && alloc_ok)
        begin
            callee_mem[new_slot] <= callee_reg;
        end
        callee_rd <= callee_mem[head_sel];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ALLOC && alloc_ok)
            calls_mem[new_slot] <= 32'd1;
        else if (state_reg == S_CHK && callee_rd == callee_reg)
            calls_mem[head_sel] <= bumped;
        calls_rd <= calls_mem[head_sel];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ALLOC && alloc_ok)
            next_mem[new_slot] <= head_reg;
        else if (state_reg == S_MOVE1)
            next_mem[prev_reg] <= next_rd;
        else if (state_reg == S_MOVE2)
            next_mem[cur_reg] <= head_reg;
        next_rd <= next_mem[head_sel];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            free_reg <= '0;
            o_valid_reg <= 1'b0;
            at_head_reg <= 1'b0;
            steps_reg <= '0;
        end
        else
        begin
            if (res.ready && o_valid_reg)
                o_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + BW'(1);
                    if (clr_reg == BW'(BUCKET_COUNT - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (evt.valid && evt.ready)
                    begin
                        callee_reg <= evt.callee_pc;
                        bucket_reg <= BW'(bucket_wide);
                        o_slot_reg <= '0;
                        o_count_reg <= '0;
                        if (!en_reg)
                        begin
                            o_outcome_reg <= cac_pkg::OUT_OFF;
                            o_valid_reg <= 1'b1;
                        end
                        else if (!in_range)
                        begin
                            o_outcome_reg <= cac_pkg::OUT_RANGE;
                            o_valid_reg <= 1'b1;
                        end
                        else
                            state_reg <= S_HEAD;
                    end
                end
                S_HEAD:
                    state_reg <= S_HWAIT;
                S_HWAIT:
                begin
                    head_reg <= head_rd;
                    at_head_reg <= 1'b1;
                    prev_reg <= head_rd;
                    steps_reg <= '0;
                    state_reg <= (head_rd == '0) ? S_ALLOC : S_NWAIT;
                end
                S_NWAIT:
                    state_reg <= S_CHK;
                S_CHK:
                begin
                    if (callee_rd == callee_reg)
                    begin
                        o_slot_reg <= head_sel;
                        o_count_reg <= bumped;
                        if (at_head_reg)
                        begin
                            o_outcome_reg <= cac_pkg::OUT_HEAD;
                            o_valid_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            o_outcome_reg <= cac_pkg::OUT_MOVED;
                            state_reg <= S_MOVE1;
                        end
                    end
                    else
                    begin
                        if (!at_head_reg)
                            prev_reg <= cur_reg;
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    if (next_rd == '0 || steps_reg[SW])
                        state_reg <= S_ALLOC;
                    else
                    begin
                        cur_reg <= next_rd;
                        at_head_reg <= 1'b0;
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                    state_reg <= S_NWAIT;
                S_MOVE1:
                    state_reg <= S_MOVE2;
                S_MOVE2:
                begin
                    o_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_ALLOC:
                begin
                    if (!alloc_ok)
                    begin
                        o_outcome_reg <= cac_pkg::OUT_FULL;
                        o_slot_reg <= '0;
                        o_count_reg <= '0;
                    end
                    else
                    begin
                        o_outcome_reg <= cac_pkg::OUT_NEW;
                        o_slot_reg <= new_slot;
                        o_count_reg <= 32'd1;
                        free_reg <= new_slot;
                    end
                    o_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: design/cac_checker.sv
`include "call_arc_counter_unit_defines.svh"
module cac_props (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  outcome,
    input logic [9:0]  arc_slot,
    input logic [31:0] call_count
);
    logic stalled;
    logic dropped;
    logic new_arc;

    assign stalled = out_valid && !out_ready;
    assign dropped = out_valid && (outcome >= cac_pkg::OUT_OFF);
    assign new_arc = out_valid && (outcome == cac_pkg::OUT_NEW);

    `CAC_ASSERT_IMP(a_busy, clk, rst_n, out_valid, !in_ready)
    `CAC_ASSERT_NEXT(a_hold, clk, rst_n, stalled, out_valid && $stable(call_count))
    `CAC_ASSERT_IMP(a_drop, clk, rst_n, dropped, arc_slot == '0 && call_count == '0)
    `CAC_ASSERT_IMP(a_new, clk, rst_n, new_arc, call_count == 32'd1 && arc_slot != '0)
    `CAC_ASSERT_NEXT(a_take, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

bind call_arc_counter_unit cac_props u_cac_props (
    .clk(clk), .rst_n(rst_n), .in_valid(evt.valid), .in_ready(evt.ready),
    .out_valid(res.valid), .out_ready(res.ready), .outcome(res.outcome),
    .arc_slot(res.arc_slot), .call_count(res.call_count)
);

FILE: sim/cac_checker.sv
module cac_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        evt_valid,
    input  logic        evt_ready,
    input  logic [31:0] evt_caller,
    input  logic [31:0] evt_callee,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic [2:0]  res_outcome,
    input  logic [9:0]  res_slot,
    input  logic [31:0] res_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending,
    output int          head_hits,
    output int          moved_hits,
    output int          new_arcs,
    output int          full_refusals
);
    typedef struct packed {
        logic [2:0]  outcome;
        logic [9:0]  slot;
        logic [31:0] count;
    } arc_result_t;

    logic        en_q;
    logic [31:0] base_q;
    logic [15:0] size_q;
    logic [10:0] limit_q;
    logic [9:0]  heads [cac_pkg::BUCKET_COUNT];
    logic [31:0] callee_mem [cac_pkg::ARC_SLOTS];
    logic [31:0] calls_mem [cac_pkg::ARC_SLOTS];
    logic [9:0]  next_mem [cac_pkg::ARC_SLOTS];
    logic [10:0] last_slot;
    arc_result_t expected_results [$];

    function automatic logic [31:0] bump_count(logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    task automatic count_call(input logic [31:0] caller, input logic [31:0] callee);
        logic [31:0] offset;
        logic [11:0] bkt;
        logic [9:0]  hd;
        logic [9:0]  prv;
        logic [9:0]  cur;
        logic [10:0] lim;
        logic [10:0] nslot;
        arc_result_t r;
        bit done;
        done = 0;
        r = '0;
        if (!en_q)
        begin
            r.outcome = cac_pkg::OUT_OFF;
            done = 1;
        end
        else
        begin
            offset = caller - {base_q[31:2], 2'b00};
            if (offset >= {16'd0, size_q}
                || offset >= 32'(cac_pkg::BUCKET_COUNT * cac_pkg::BUCKET_BYTES))
            begin
                r.outcome = cac_pkg::OUT_RANGE;
                done = 1;
            end
            else
            begin
                bkt = offset[14:3];
                hd = heads[bkt];
                if (hd != 0)
                begin
                    if (callee_mem[hd] == callee)
                    begin
                        calls_mem[hd] = bump_count(calls_mem[hd]);
                        r = '{cac_pkg::OUT_HEAD, hd, calls_mem[hd]};
                        done = 1;
                    end
                    else
                    begin
                        prv = hd;
                        for (int s = 0; s < cac_pkg::ARC_SLOTS && !done; s++)
                        begin
                            cur = next_mem[prv];
                            if (cur == 0)
                                break;
                            if (callee_mem[cur] == callee)
                            begin
                                calls_mem[cur] = bump_count(calls_mem[cur]);
                                next_mem[prv] = next_mem[cur];
                                next_mem[cur] = hd;
                                heads[bkt] = cur;
                                r = '{cac_pkg::OUT_MOVED, cur, calls_mem[cur]};
                                done = 1;
                            end
                            prv = cur;
                        end
                    end
                end
                if (!done)
                begin
                    lim = (limit_q < cac_pkg::ARC_SLOTS) ? limit_q : 11'(cac_pkg::ARC_SLOTS);
                    nslot = last_slot + 11'd1;
                    if (nslot >= lim)
                        r.outcome = cac_pkg::OUT_FULL;
                    else
                    begin
                        last_slot = nslot;
                        callee_mem[nslot[9:0]] = callee;
                        calls_mem[nslot[9:0]] = 32'd1;
                        next_mem[nslot[9:0]] = hd;
                        heads[bkt] = nslot[9:0];
                        r = '{cac_pkg::OUT_NEW, nslot[9:0], 32'd1};
                    end
                end
            end
        end
        expected_results.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        arc_result_t e;
        if (!rst_n)
        begin
            en_q <= 1'b0;
            base_q <= '0;
            size_q <= 16'd32768;
            limit_q <= 11'd1024;
            last_slot = '0;
            foreach (heads[i])
                heads[i] = '0;
            expected_results.delete();
            pending <= 0;
            fail_count <= 0;
            head_hits <= 0;
            moved_hits <= 0;
            new_arcs <= 0;
            full_refusals <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (res_outcome !== e.outcome || res_slot !== e.slot
                        || res_count !== e.count)
                    begin
                        if (res_outcome !== e.outcome)
                            $error("outcome expected %0d actual %0d", e.outcome, res_outcome);
                        if (res_slot !== e.slot)
                            $error("arc_slot expected %0d actual %0d", e.slot, res_slot);
                        if (res_count !== e.count)
                            $error("call_count expected %0d actual %0d", e.count, res_count);
                        fail_count <= fail_count + 1;
                    end
                    case (e.outcome)
                        cac_pkg::OUT_HEAD:  head_hits <= head_hits + 1;
                        cac_pkg::OUT_MOVED: moved_hits <= moved_hits + 1;
                        cac_pkg::OUT_NEW:   new_arcs <= new_arcs + 1;
                        cac_pkg::OUT_FULL:  full_refusals <= full_refusals + 1;
                        default: ;
                    endcase
                end
            end
            if (evt_valid && evt_ready)
                count_call(evt_caller, evt_callee);
            pending <= expected_results.size();
            if (psel && penable && pwrite)
            begin
                case (paddr[3:2])
                    cac_pkg::REG_ENABLE: en_q <= pwdata[0];
                    cac_pkg::REG_BASE:   base_q <= pwdata;
                    cac_pkg::REG_SIZE:   size_q <= pwdata[15:0];
                    cac_pkg::REG_LIMIT:  limit_q <= pwdata[10:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

FILE: sim/tb_call_arc_counter_unit.sv
module tb_call_arc_counter_unit;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          head_hits;
    int          moved_hits;
    int          new_arcs;
    int          full_refusals;
    int          idle_cycles;
    int          send_idle_pct;
    int          stall_pct;
    int          words_sent;
    logic [31:0] cur_base;

    cac_event_if  evt ();
    cac_result_if res ();

    call_arc_counter_unit dut (
        .clk(clk), .rst_n(rst_n), .evt(evt), .res(res),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    cac_checker arc_check (
        .clk(clk), .rst_n(rst_n),
        .evt_valid(evt.valid), .evt_ready(evt.ready),
        .evt_caller(evt.caller_pc), .evt_callee(evt.callee_pc),
        .res_valid(res.valid), .res_ready(res.ready),
        .res_outcome(res.outcome), .res_slot(res.arc_slot), .res_count(res.call_count),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .pending(pending), .head_hits(head_hits),
        .moved_hits(moved_hits), .new_arcs(new_arcs), .full_refusals(full_refusals)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else
            res.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((evt.valid && evt.ready) || (res.valid && res.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == cac_pkg::REG_BASE)
            cur_base = value;
        @(posedge clk);
    endtask

    task automatic drain();
        evt.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic send_call(input logic [31:0] caller, input logic [31:0] callee);
        while ($urandom_range(99) < send_idle_pct)
        begin
            evt.valid <= 1'b0;
            @(posedge clk);
        end
        evt.valid <= 1'b1;
        evt.caller_pc <= caller;
        evt.callee_pc <= callee;
        @(posedge clk);
        while (!evt.ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic random_call(input int nbuckets);
        logic [31:0] caller;
        logic [31:0] callee;
        int r;
        r = $urandom_range(99);
        if (r < 85)
            caller = cur_base + ($urandom_range(nbuckets - 1) * 8) + $urandom_range(7);
        else
            caller = $urandom;
        if ($urandom_range(99) < 80)
            callee = 32'h1000 + $urandom_range(5);
        else
            callee = $urandom;
        send_call(caller, callee);
    endtask

    task automatic run_phase(input int n, input int nbuckets, input int sidle, input int stl);
        send_idle_pct = sidle;
        stall_pct = stl;
        repeat (n) random_call(nbuckets);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        evt.valid = 1'b0;
        evt.caller_pc = '0;
        evt.callee_pc = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        words_sent = 0;
        cur_base = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_call(32'h0, 32'h0);
        send_call(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();
        write_reg(cac_pkg::REG_ENABLE, 32'd1);
        send_call(32'h0, 32'h0);
        send_call(32'h0, 32'h0);
        send_call(32'h0, 32'hFFFF_FFFF);
        send_call(32'h4, 32'h0);
        send_call(32'h7FFF, 32'hFFFF_FFFF);
        send_call(32'h8000, 32'h5);
        send_call(32'hFFFF_FFFF, 32'h5);
        drain();
        write_reg(cac_pkg::REG_BASE, 32'hFFFF_FFF3);
        write_reg(cac_pkg::REG_SIZE, 32'd20);
        send_call(32'hFFFF_FFF0, 32'hA);
        send_call(32'h3, 32'hA);
        send_call(32'h4, 32'hA);
        send_call(32'hFFFF_FFEF, 32'hA);
        drain();
        write_reg(cac_pkg::REG_SIZE, 32'd0);
        send_call(32'hFFFF_FFF0, 32'hA);
        drain();
        write_reg(cac_pkg::REG_LIMIT, 32'd1);
        write_reg(cac_pkg::REG_BASE, 32'd0);
        write_reg(cac_pkg::REG_SIZE, 32'd32768);
        send_call(32'h100, 32'h77);
        drain();
        write_reg(cac_pkg::REG_LIMIT, 32'd24);
        run_phase(300, 4, 0, 0);
        drain();
        write_reg(cac_pkg::REG_LIMIT, 32'd2047);
        write_reg(cac_pkg::REG_BASE, 32'h8000_0002);
        write_reg(cac_pkg::REG_SIZE, 32'd32768);
        run_phase(400, 64, 78, 0);
        drain();
        write_reg(cac_pkg::REG_ENABLE, 32'd0);
        run_phase(50, 64, 0, 0);
        drain();
        write_reg(cac_pkg::REG_ENABLE, 32'd1);
        write_reg(cac_pkg::REG_SIZE, 32'd4000);
        run_phase(400, 500, 0, 78);
        drain();
        write_reg(cac_pkg::REG_LIMIT, 32'd1024);
        write_reg(cac_pkg::REG_BASE, 32'd0);
        write_reg(cac_pkg::REG_SIZE, 32'd65535);
        send_call(32'h0000_9000, 32'h1000);
        run_phase(800, 4096, 36, 36);
        send_idle_pct = 0;
        stall_pct = 0;

        drain();
        repeat (20) @(posedge clk);
        $display("Sent %0d call words: %0d head hits, %0d moved hits, %0d new arcs,",
            words_sent, head_hits, moved_hits, new_arcs);
        $display("%0d refusals when full, across several register settings and stall mixes.",
            full_refusals);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
